// ===== design/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared field widths, stream packing and sextant codes of the rgb to hsv core
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // every field on the stream ports is this wide
  localparam int FIELD_BITS = 16;
  localparam int FIELDS     = 4;
  localparam int TDATA_BITS = FIELD_BITS * FIELDS;

  // bit offsets of the fields inside tdata
  localparam int OFS_0 = 0;
  localparam int OFS_1 = FIELD_BITS;
  localparam int OFS_2 = 2 * FIELD_BITS;
  localparam int OFS_3 = 3 * FIELD_BITS;

  // which channel holds the maximum, and which side of red for hue wrap
  typedef enum logic [1:0] {
    SEXT_RED_UP = 2'd0,  // red max, green >= blue
    SEXT_RED_DN = 2'd1,  // red max, green <  blue
    SEXT_GREEN  = 2'd2,  // green max
    SEXT_BLUE   = 2'd3   // blue max
  } sext_e;

endpackage

// ===== design/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_front
// three register stages: max/min and sextant, channel span, divider operands
// ----------------------------------------------------------------------------
module rgbhsv_front #(
  parameter int CW = 16
) (
  input  logic            clk_i,
  input  logic [2:0]      en_i,
  input  logic [CW-1:0]   red_i,
  input  logic [CW-1:0]   green_i,
  input  logic [CW-1:0]   blue_i,
  input  logic [CW-1:0]   alpha_i,
  output logic [CW+2:0]   hue_num_o,
  output logic [CW+2:0]   hue_div_o,
  output logic [CW-1:0]   sat_hi_o,
  output logic [CW-1:0]   sat_lo_o,
  output logic [CW-1:0]   sat_div_o,
  output logic            zero_o,
  output logic [CW-1:0]   value_o,
  output logic [CW-1:0]   alpha_o
);

  // stage 0
  logic [CW-1:0]       hi_d, lo_d, hi0_q, lo0_q, alpha0_q;
  logic signed [CW:0]  diff_d, diff0_q;
  rgbhsv_pkg::sext_e   sext_d, sext0_q;
  logic                red_max, green_max;

  // stage 1
  logic [CW-1:0]       span_d, span1_q, hi1_q, alpha1_q;
  logic signed [CW:0]  diff1_q;
  rgbhsv_pkg::sext_e   sext1_q;

  // stage 2
  logic [CW+2:0]       kd;
  logic signed [CW+3:0] num_s;
  logic [2*CW-1:0]     sat_n;
  logic [CW+2:0]       num_q, div6_q;
  logic [2*CW-1:0]     sat_n_q;
  logic [CW-1:0]       hi2_q, alpha2_q;
  logic                zero_q;

  always_comb begin
    red_max   = (red_i >= green_i) && (red_i >= blue_i);
    green_max = !red_max && (green_i >= blue_i);
    hi_d      = red_max ? red_i : (green_max ? green_i : blue_i);
    lo_d      = (red_i <= green_i) ? ((red_i <= blue_i) ? red_i : blue_i)
                                   : ((green_i <= blue_i) ? green_i : blue_i);
    if (red_max) begin
      diff_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
      sext_d = (green_i >= blue_i) ? rgbhsv_pkg::SEXT_RED_UP : rgbhsv_pkg::SEXT_RED_DN;
    end else if (green_max) begin
      diff_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
      sext_d = rgbhsv_pkg::SEXT_GREEN;
    end else begin
      diff_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
      sext_d = rgbhsv_pkg::SEXT_BLUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      hi0_q    <= hi_d;
      lo0_q    <= lo_d;
      diff0_q  <= diff_d;
      sext0_q  <= sext_d;
      alpha0_q <= alpha_i;
    end
  end

  assign span_d = hi0_q - lo0_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      span1_q  <= span_d;
      diff1_q  <= diff0_q;
      sext1_q  <= sext0_q;
      hi1_q    <= hi0_q;
      alpha1_q <= alpha0_q;
    end
  end

  // sextant offset k * span, then the signed difference on top
  always_comb begin
    unique case (sext1_q)
      rgbhsv_pkg::SEXT_RED_UP: kd = '0;
      rgbhsv_pkg::SEXT_RED_DN: kd = ({3'b0, span1_q} << 2) + ({3'b0, span1_q} << 1);
      rgbhsv_pkg::SEXT_GREEN:  kd = {3'b0, span1_q} << 1;
      rgbhsv_pkg::SEXT_BLUE:   kd = {3'b0, span1_q} << 2;
      default:                 kd = '0;
    endcase
    num_s = $signed({1'b0, kd}) + (CW+4)'(diff1_q);
    // span * full scale = span * 2^CW - span
    sat_n = {span1_q, {CW{1'b0}}} - (2*CW)'(span1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      num_q    <= num_s[CW+2:0];
      div6_q   <= ({3'b0, span1_q} << 2) + ({3'b0, span1_q} << 1);
      sat_n_q  <= sat_n;
      zero_q   <= (span1_q == '0);
      hi2_q    <= hi1_q;
      alpha2_q <= alpha1_q;
    end
  end

  assign hue_num_o = num_q;
  assign hue_div_o = div6_q;
  assign sat_hi_o  = sat_n_q[2*CW-1:CW];
  assign sat_lo_o  = sat_n_q[CW-1:0];
  assign sat_div_o = hi2_q;
  assign zero_o    = zero_q;
  assign value_o   = hi2_q;
  assign alpha_o   = alpha2_q;

endmodule

// ===== design/rgbhsv_div.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module rgbhsv_div #(
  parameter int DW = 19,
  parameter int QW = 16
) (
  input  logic          clk_i,
  input  logic [QW-1:0] en_i,
  input  logic [DW-1:0] rem_i,   // upper dividend part, below the divisor
  input  logic [QW-1:0] low_i,   // lower dividend bits, shifted in msb first
  input  logic [DW-1:0] div_i,
  output logic [QW-1:0] quot_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] div_q  [QW];
  logic [QW-1:0] low_q  [QW];
  logic [QW-1:0] quot_q [QW];

  logic [DW-1:0] rem_p  [QW];
  logic [DW-1:0] div_p  [QW];
  logic [QW-1:0] low_p  [QW];
  logic [QW-1:0] quot_p [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] sub;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_p[k]  = rem_i;
      assign div_p[k]  = div_i;
      assign low_p[k]  = low_i;
      assign quot_p[k] = '0;
    end else begin : g_next
      assign rem_p[k]  = rem_q[k-1];
      assign div_p[k]  = div_q[k-1];
      assign low_p[k]  = low_q[k-1];
      assign quot_p[k] = quot_q[k-1];
    end

    assign trial = {rem_p[k], low_p[k][QW-1]};
    assign sub   = trial - {1'b0, div_p[k]};
    assign take  = (trial >= {1'b0, div_p[k]});

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k]  <= take ? sub[DW-1:0] : trial[DW-1:0];
        div_q[k]  <= div_p[k];
        low_q[k]  <= {low_p[k][QW-2:0], 1'b0};
        quot_q[k] <= {quot_p[k][QW-2:0], take};
      end
    end
  end

  assign quot_o = quot_q[QW-1];

endmodule

// ===== design/rgb_to_hsv_converter_core.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// streaming rgba to hsva pixel converter
// ----------------------------------------------------------------------------
// usage:
//   slave stream takes one pixel per transfer, master stream gives one hsva
//   pixel per transfer, in the same order. pixels are independent.
// latency and throughput:
//   3 + CHANNEL_BITS register stages (19 at the default): three front stages
//   for max/min, span and divider operands, then one stage per quotient bit
//   in the two parallel restoring dividers (hue and saturation). one pixel
//   per clock is sustained while output is ready; divider depth sets latency.
// stalls:
//   each stage holds a valid bit; a stage loads when it is empty or when the
//   stage after it moves, so bubbles collapse and the input keeps taking
//   transfers while a result waits, until every stage is full.
// reset:
//   rst_ni clears all valid bits at once; data registers are not reset.
// special cases:
//   when max equals min (grey or black pixel) the dividers see a zero span;
//   hue and saturation are forced to zero at the output.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core #(
  parameter int CHANNEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: red, green, blue, alpha_in (16 bits each, lowest first)
  input  logic [rgbhsv_pkg::TDATA_BITS-1:0] s_axis_tdata_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: hue, saturation, value, alpha_out (16 bits each, lowest first)
  output logic [rgbhsv_pkg::TDATA_BITS-1:0] m_axis_tdata_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i
);

  localparam int CW     = CHANNEL_BITS;
  localparam int FW     = rgbhsv_pkg::FIELD_BITS;
  localparam int FRONT  = 3;
  localparam int STAGES = FRONT + CW;

  // valid bit per stage and the ready chain from the output backwards
  logic [STAGES-1:0] v_q;
  logic [STAGES:0]   ready;
  logic [STAGES-1:0] v_in;

  // front outputs
  logic [CW+2:0] hue_num, hue_div;
  logic [CW-1:0] sat_hi, sat_lo, sat_div, value_f, alpha_f;
  logic          zero_f;

  // divider results
  logic [CW-1:0] hue_quot, sat_quot;

  // sideband that rides along the divider stages
  logic [CW-1:0] value_q [CW];
  logic [CW-1:0] alpha_q [CW];
  logic          zero_q  [CW];

  logic [CW-1:0] hue_res, sat_res;

  assign ready[STAGES] = m_axis_tready_i;
  assign v_in[0]       = s_axis_tvalid_i;

  for (genvar i = 0; i < STAGES; i++) begin : g_ctl
    assign ready[i] = !v_q[i] || ready[i+1];
    if (i > 0) begin : g_vin
      assign v_in[i] = v_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (ready[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  assign s_axis_tready_o = ready[0];

  // field bits above the channel width are dropped here
  rgbhsv_front #(
    .CW (CW)
  ) u_front (
    .clk_i     (clk_i),
    .en_i      (ready[FRONT-1:0]),
    .red_i     (CW'(s_axis_tdata_i[rgbhsv_pkg::OFS_0 +: FW])),
    .green_i   (CW'(s_axis_tdata_i[rgbhsv_pkg::OFS_1 +: FW])),
    .blue_i    (CW'(s_axis_tdata_i[rgbhsv_pkg::OFS_2 +: FW])),
    .alpha_i   (CW'(s_axis_tdata_i[rgbhsv_pkg::OFS_3 +: FW])),
    .hue_num_o (hue_num),
    .hue_div_o (hue_div),
    .sat_hi_o  (sat_hi),
    .sat_lo_o  (sat_lo),
    .sat_div_o (sat_div),
    .zero_o    (zero_f),
    .value_o   (value_f),
    .alpha_o   (alpha_f)
  );

  // hue: (k*span + diff) * 2^CW / (6*span), numerator below the divisor
  rgbhsv_div #(
    .DW (CW + 3),
    .QW (CW)
  ) u_hue_div (
    .clk_i  (clk_i),
    .en_i   (ready[FRONT +: CW]),
    .rem_i  (hue_num),
    .low_i  ('0),
    .div_i  (hue_div),
    .quot_o (hue_quot)
  );

  // saturation: span * full scale / max
  rgbhsv_div #(
    .DW (CW),
    .QW (CW)
  ) u_sat_div (
    .clk_i  (clk_i),
    .en_i   (ready[FRONT +: CW]),
    .rem_i  (sat_hi),
    .low_i  (sat_lo),
    .div_i  (sat_div),
    .quot_o (sat_quot)
  );

  for (genvar k = 0; k < CW; k++) begin : g_side
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (ready[FRONT+k]) begin
          value_q[k] <= value_f;
          alpha_q[k] <= alpha_f;
          zero_q[k]  <= zero_f;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (ready[FRONT+k]) begin
          value_q[k] <= value_q[k-1];
          alpha_q[k] <= alpha_q[k-1];
          zero_q[k]  <= zero_q[k-1];
        end
      end
    end
  end

  // zero span means grey or black: no meaningful quotient
  assign hue_res = zero_q[CW-1] ? '0 : hue_quot;
  assign sat_res = zero_q[CW-1] ? '0 : sat_quot;

  assign m_axis_tvalid_o = v_q[STAGES-1];
  assign m_axis_tdata_o  = {FW'(alpha_q[CW-1]), FW'(value_q[CW-1]),
                            FW'(sat_res), FW'(hue_res)};

endmodule

// ===== design/rgbhsv_checker.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_checker
// port level checks of the rgb to hsv core, bound to the top level
// ----------------------------------------------------------------------------
module rgbhsv_checker #(
  parameter int CHANNEL_BITS = 16
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic [rgbhsv_pkg::TDATA_BITS-1:0] s_axis_tdata_i,
  input logic                              s_axis_tvalid_i,
  input logic                              s_axis_tready_o,
  input logic [rgbhsv_pkg::TDATA_BITS-1:0] m_axis_tdata_o,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i
);

  localparam int FW = rgbhsv_pkg::FIELD_BITS;

  logic [FW-1:0] hue_f, sat_f, value_f;

  assign hue_f   = m_axis_tdata_o[rgbhsv_pkg::OFS_0 +: FW];
  assign sat_f   = m_axis_tdata_o[rgbhsv_pkg::OFS_1 +: FW];
  assign value_f = m_axis_tdata_o[rgbhsv_pkg::OFS_2 +: FW];

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output transfer changed while stalled");

  // with the output free the pipeline must take a new pixel
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled with free output");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (value_f == '0) |-> (sat_f == '0) && (hue_f == '0))
    else $error("black pixel with nonzero hue or saturation");

  // zero saturation only comes from a grey pixel, whose hue is zero
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (CHANNEL_BITS <= FW) && (sat_f == '0) |-> (hue_f == '0))
    else $error("grey pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_checker #(
  .CHANNEL_BITS (CHANNEL_BITS)
) u_rgbhsv_checker (.*);
